/* sv/tdm_pkg.sv */
// task deadline monitor package: transaction types, command codes, fsm states
// no dependencies
package tdm_pkg;

	localparam int NUM_TASKS = 4;
	localparam int TASK_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int REC_W = 13 * 32;

	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_REPORT = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_GATE   = 3'd3,
		CMD_GRESET = 3'd4,
		CMD_READ   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ACTIVE   = 3'd0,
		REG_PERIOD0  = 3'd1,
		REG_PERIOD1  = 3'd2,
		REG_PERIOD2  = 3'd3,
		REG_PERIOD3  = 3'd4,
		REG_CRITICAL = 3'd5,
		REG_TOLER    = 3'd6
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_WAIT, ST_EXEC, ST_DIV, ST_WB, ST_GSCAN, ST_GACK, ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [1:0]  task_index;
		logic [31:0] now_time;
		logic [31:0] start_time;
		logic [31:0] complete_time;
	} in_t;

	typedef struct packed {
		logic        ok;
		logic        healthy;
		logic [31:0] skipped_count;
		logic [31:0] miss_count;
		logic [31:0] consecutive_misses;
		logic [31:0] overrun_count;
		logic [31:0] run_total;
		logic [31:0] last_runtime;
		logic [31:0] max_runtime;
		logic [31:0] max_lateness;
		logic [31:0] last_complete;
		logic [31:0] next_release;
	} out_t;

	// one memory word per task
	typedef struct packed {
		logic [31:0] release_time;
		logic [31:0] skips;
		logic [31:0] misses;
		logic [31:0] streak;
		logic [31:0] overruns;
		logic [31:0] runs;
		logic [31:0] rt_last;
		logic [31:0] rt_peak;
		logic [31:0] late_peak;
		logic [31:0] completed;
		logic [31:0] ack_skips;
		logic [31:0] ack_overruns;
		logic [31:0] spare;
	} rec_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] a);
		return (a == '1) ? a : a + 32'd1;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

endpackage

/* sv/tdm_ram.sv */
// generic single-port ram with registered read
// no dependencies
module tdm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* sv/tdm_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// uses tdm_pkg
module tdm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tdm_pkg::div_req_t req,
	output tdm_pkg::div_rsp_t rsp
);
	logic [31:0] quo_q, den_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;

	// remainder stays below the divisor, so a non-negative trial fits 32 bits
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

/* sv/task_deadline_monitor.sv */
// task deadline monitor top: config registers, command sequencer, task memory
// uses tdm_pkg, tdm_ram, tdm_div
//
//  channel | signals                         | transaction when
//  in      | in_valid, in_stall, in_data     | in_valid & !in_stall
//  out     | out_valid, out_stall, out_data  | out_valid & !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index,| cfg_valid & cfg_ready
//          | cfg_data                        |
//
// one transaction at a time; input stalls from acceptance until the result is taken
// read, unused code, report run not due: no memory write; report run: waits for the divider
// start, clear: walk the active tasks; gate reset walks all tasks
// gate check: scans the active tasks, then acknowledges them; stops early when a task fails
// reset clears the task memory in a pass over every task before input is taken
// a result waits in its output register while out_stall is high
module task_deadline_monitor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tdm_pkg::in_t     in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output tdm_pkg::out_t    out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	logic [2:0]  active_q;
	logic [31:0] period_q [tdm_pkg::NUM_TASKS];
	logic [3:0]  crit_q;
	logic [31:0] tol_q;
	logic        started_q, gate_q, clr_q, fin_q, ack_q, ok_q;

	tdm_pkg::state_t state_q, state_d;
	tdm_pkg::in_t    cmd_q;
	tdm_pkg::rec_t   rec_q, rdata, wdata;
	tdm_pkg::out_t   out_q;
	logic [2:0]      addr_q;
	logic [2:0]      lim, wlim;
	logic            we;
	logic [31:0]     per, late, rt, since_rel;
	tdm_pkg::div_req_t dreq;
	tdm_pkg::div_rsp_t drsp;
	logic            in_walk, due;
	logic        is_crit, fresh_ok, gfail;
	logic [32:0] fresh_lim;
	logic [31:0] skipped, new_streak;
	logic        miss;

	assign cfg_ready = 1'b1;
	assign lim = (active_q > 3'(tdm_pkg::NUM_TASKS)) ? 3'(tdm_pkg::NUM_TASKS) : active_q;
	// gate reset clears the acknowledgements of every task, active or not
	assign wlim = (cmd_q.command == tdm_pkg::CMD_GRESET) ? 3'(tdm_pkg::NUM_TASKS) : lim;
	assign in_walk = addr_q < wlim;
	assign per = (period_q[addr_q[1:0]] == '0) ? 32'd1 : period_q[addr_q[1:0]];
	assign late = cmd_q.start_time - rec_q.release_time;
	assign rt = cmd_q.complete_time - cmd_q.start_time;
	assign since_rel = cmd_q.now_time - rec_q.release_time;
	// due when started, the task is active and now is at or after the release, modulo 2^32
	assign due = started_q && ({1'b0, cmd_q.task_index} < lim) && !since_rel[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int i = 0; i < tdm_pkg::NUM_TASKS; i++) period_q[i] <= 32'd1;
			crit_q <= '0;
			tol_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdm_pkg::REG_ACTIVE:   active_q <= cfg_data[2:0];
				tdm_pkg::REG_PERIOD0:  period_q[0] <= cfg_data;
				tdm_pkg::REG_PERIOD1:  period_q[1] <= cfg_data;
				tdm_pkg::REG_PERIOD2:  period_q[2] <= cfg_data;
				tdm_pkg::REG_PERIOD3:  period_q[3] <= cfg_data;
				tdm_pkg::REG_CRITICAL: crit_q <= cfg_data[3:0];
				tdm_pkg::REG_TOLER:    tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tdm_ram #(.WIDTH(tdm_pkg::REC_W), .DEPTH(tdm_pkg::NUM_TASKS)) u_ram (
		.clk(clk), .we(we), .addr(addr_q[1:0]), .wdata(wdata), .rdata(rdata)
	);

	tdm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_stall = (state_q != tdm_pkg::ST_IDLE) || clr_q;
	assign out_valid = (state_q == tdm_pkg::ST_OUT);
	assign out_data = out_q;

	// record modification for the current command
	always_comb begin
		wdata = rec_q;
		skipped = drsp.quotient;
		miss = ({1'b0, late} + {1'b0, rt}) > {1'b0, per};
		new_streak = miss ? tdm_pkg::sat_inc(rec_q.streak) : '0;
		fresh_lim = {1'b0, per} + {1'b0, tol_q};
		is_crit = crit_q[addr_q[1:0]];
		fresh_ok = (rec_q.runs != '0) &&
			({1'b0, cmd_q.now_time - rec_q.completed} <= fresh_lim);
		gfail = is_crit && (!fresh_ok || rec_q.skips != rec_q.ack_skips ||
			rec_q.overruns != rec_q.ack_overruns);
		case (cmd_q.command)
			tdm_pkg::CMD_START: wdata.release_time = cmd_q.now_time + per;
			tdm_pkg::CMD_CLEAR: begin
				wdata.rt_peak = '0;
				wdata.late_peak = '0;
			end
			tdm_pkg::CMD_GRESET: begin
				wdata.ack_skips = '0;
				wdata.ack_overruns = '0;
			end
			tdm_pkg::CMD_GATE: begin
				wdata.ack_skips = rec_q.skips;
				wdata.ack_overruns = rec_q.overruns;
			end
			tdm_pkg::CMD_REPORT: begin
				wdata.skips = tdm_pkg::sat_add(rec_q.skips, skipped);
				wdata.release_time = rec_q.release_time + (skipped + 32'd1) * per;
				wdata.rt_last = rt;
				if (rt > rec_q.rt_peak) wdata.rt_peak = rt;
				if (late > rec_q.late_peak) wdata.late_peak = late;
				wdata.streak = new_streak;
				if (miss) begin
					wdata.misses = tdm_pkg::sat_inc(rec_q.misses);
					if (new_streak == 32'd2) wdata.overruns = tdm_pkg::sat_inc(rec_q.overruns);
				end
				wdata.runs = tdm_pkg::sat_inc(rec_q.runs);
				wdata.completed = cmd_q.complete_time;
			end
			default: ;
		endcase
		if (clr_q) wdata = '0;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		we = clr_q;
		dreq.start = 1'b0;
		dreq.dividend = late;
		dreq.divisor = per;
		case (state_q)
			tdm_pkg::ST_IDLE: if (in_valid && !clr_q) state_d = tdm_pkg::ST_RD;
			tdm_pkg::ST_RD: state_d = tdm_pkg::ST_WAIT;
			tdm_pkg::ST_WAIT: state_d = tdm_pkg::ST_EXEC;
			tdm_pkg::ST_EXEC: begin
				if (fin_q) state_d = tdm_pkg::ST_OUT;
				else begin
					case (cmd_q.command)
						tdm_pkg::CMD_REPORT: begin
							if (due) begin
								dreq.start = 1'b1;
								state_d = tdm_pkg::ST_DIV;
							end else state_d = tdm_pkg::ST_OUT;
						end
						tdm_pkg::CMD_START, tdm_pkg::CMD_CLEAR, tdm_pkg::CMD_GRESET: begin
							if (in_walk) state_d = tdm_pkg::ST_WB;
							else state_d = tdm_pkg::ST_RD;
						end
						tdm_pkg::CMD_GATE: begin
							if (!gate_q || !in_walk) state_d = tdm_pkg::ST_RD;
							else if (ack_q) state_d = tdm_pkg::ST_GACK;
							else state_d = tdm_pkg::ST_GSCAN;
						end
						default: state_d = tdm_pkg::ST_OUT;
					endcase
				end
			end
			tdm_pkg::ST_DIV: if (drsp.done) state_d = tdm_pkg::ST_WB;
			tdm_pkg::ST_WB: begin
				we = 1'b1;
				state_d = tdm_pkg::ST_RD;
			end
			tdm_pkg::ST_GSCAN: state_d = tdm_pkg::ST_RD;
			tdm_pkg::ST_GACK: begin
				we = 1'b1;
				state_d = tdm_pkg::ST_RD;
			end
			tdm_pkg::ST_OUT: if (!out_stall) state_d = tdm_pkg::ST_IDLE;
			default: state_d = tdm_pkg::ST_IDLE;
		endcase
	end

	// fin_q: next exec emits the result; ack_q: gate acknowledge pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdm_pkg::ST_IDLE;
			started_q <= 1'b0;
			gate_q <= 1'b1;
			clr_q <= 1'b1;
			addr_q <= '0;
			fin_q <= 1'b0;
			ack_q <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				if (addr_q == 3'(tdm_pkg::NUM_TASKS - 1)) begin
					clr_q <= 1'b0;
					addr_q <= '0;
				end else addr_q <= addr_q + 3'd1;
			end else begin
				case (state_q)
					tdm_pkg::ST_IDLE: if (in_valid) begin
						ok_q <= 1'b0;
						ack_q <= 1'b0;
						case (in_data.command)
							tdm_pkg::CMD_START, tdm_pkg::CMD_CLEAR, tdm_pkg::CMD_GRESET,
							tdm_pkg::CMD_GATE: begin
								addr_q <= '0;
								fin_q <= 1'b0;
							end
							tdm_pkg::CMD_REPORT: begin
								addr_q <= {1'b0, in_data.task_index};
								fin_q <= 1'b0;
							end
							default: begin
								addr_q <= {1'b0, in_data.task_index};
								fin_q <= 1'b1;
							end
						endcase
					end
					tdm_pkg::ST_EXEC: if (!fin_q) begin
						case (cmd_q.command)
							tdm_pkg::CMD_START, tdm_pkg::CMD_CLEAR, tdm_pkg::CMD_GRESET: begin
								if (!in_walk) begin
									if (cmd_q.command == tdm_pkg::CMD_START) started_q <= 1'b1;
									if (cmd_q.command == tdm_pkg::CMD_GRESET) gate_q <= 1'b1;
									fin_q <= 1'b1;
									addr_q <= {1'b0, cmd_q.task_index};
								end
							end
							tdm_pkg::CMD_GATE: begin
								if (!gate_q) begin
									fin_q <= 1'b1;
									addr_q <= {1'b0, cmd_q.task_index};
								end else if (!in_walk) begin
									if (ack_q) begin
										ok_q <= 1'b1;
										fin_q <= 1'b1;
										addr_q <= {1'b0, cmd_q.task_index};
									end else begin
										ack_q <= 1'b1;
										addr_q <= '0;
									end
								end
							end
							default: ;
						endcase
					end
					tdm_pkg::ST_WB: begin
						if (cmd_q.command == tdm_pkg::CMD_REPORT) begin
							ok_q <= 1'b1;
							fin_q <= 1'b1;
						end else addr_q <= addr_q + 3'd1;
					end
					tdm_pkg::ST_GSCAN: begin
						if (gfail) begin
							gate_q <= 1'b0;
							fin_q <= 1'b1;
							addr_q <= {1'b0, cmd_q.task_index};
						end else addr_q <= addr_q + 3'd1;
					end
					tdm_pkg::ST_GACK: addr_q <= addr_q + 3'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tdm_pkg::ST_IDLE && in_valid && !clr_q) cmd_q <= in_data;
		if (state_q == tdm_pkg::ST_WAIT) rec_q <= rdata;
		if (state_q == tdm_pkg::ST_EXEC && state_d == tdm_pkg::ST_OUT) begin
			out_q.ok <= ok_q;
			out_q.healthy <= gate_q;
			out_q.skipped_count <= rec_q.skips;
			out_q.miss_count <= rec_q.misses;
			out_q.consecutive_misses <= rec_q.streak;
			out_q.overrun_count <= rec_q.overruns;
			out_q.run_total <= rec_q.runs;
			out_q.last_runtime <= rec_q.rt_last;
			out_q.max_runtime <= rec_q.rt_peak;
			out_q.max_lateness <= rec_q.late_peak;
			out_q.last_complete <= rec_q.completed;
			out_q.next_release <= rec_q.release_time;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tdm_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !clr_q)
		else $error("result during clearing pass");
	a_div_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> (state_q == tdm_pkg::ST_EXEC))
		else $error("divider started outside exec");
`endif
endmodule

/* dv/tb_task_deadline_monitor.sv */
// testbench for task_deadline_monitor: random and directed commands, scoreboard check
// depends on tdm_pkg and the task_deadline_monitor rtl
module tb_task_deadline_monitor;

	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	// behavioral copy of the monitor with its own state and register file
	class deadline_scoreboard;
		logic [2:0]  n_active;
		logic [31:0] period[4];
		logic [3:0]  crit;
		logic [31:0] toler;
		bit          armed;
		logic [31:0] rel[4], skp[4], mis[4], strk[4], ovr[4], nrun[4];
		logic [31:0] rtl_last[4], rtpk[4], ltpk[4], done_at[4], askp[4], aovr[4];
		bit          latch;
		tdm_pkg::out_t pending[$];
		int          errors;

		function void clear_all();
			n_active = 0; crit = 0; toler = 0; armed = 0; latch = 1; errors = 0;
			for (int i = 0; i < 4; i++) begin
				period[i] = 1; rel[i] = 0; skp[i] = 0; mis[i] = 0; strk[i] = 0;
				ovr[i] = 0; nrun[i] = 0; rtl_last[i] = 0; rtpk[i] = 0; ltpk[i] = 0;
				done_at[i] = 0; askp[i] = 0; aovr[i] = 0;
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				tdm_pkg::REG_ACTIVE:   n_active = val[2:0];
				tdm_pkg::REG_PERIOD0:  period[0] = val;
				tdm_pkg::REG_PERIOD1:  period[1] = val;
				tdm_pkg::REG_PERIOD2:  period[2] = val;
				tdm_pkg::REG_PERIOD3:  period[3] = val;
				tdm_pkg::REG_CRITICAL: crit = val[3:0];
				tdm_pkg::REG_TOLER:    toler = val;
				default: ;
			endcase
		endfunction

		function logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? MAX32 : s[31:0];
		endfunction

		function logic [31:0] per(int t);
			return period[t] == 0 ? 32'd1 : period[t];
		endfunction

		function int lim();
			return n_active > 4 ? 4 : n_active;
		endfunction

		function bit run_gate(logic [31:0] now);
			logic [31:0] age;
			bit fresh;
			if (!latch) return 0;
			for (int i = 0; i < lim(); i++) begin
				if (!crit[i]) continue;
				age = now - done_at[i];
				fresh = nrun[i] != 0 && {32'd0, age} <= {32'd0, per(i)} + {32'd0, toler};
				if (!fresh || skp[i] != askp[i] || ovr[i] != aovr[i]) begin
					latch = 0;
					return 0;
				end
			end
			for (int i = 0; i < lim(); i++) begin
				askp[i] = skp[i]; aovr[i] = ovr[i];
			end
			return 1;
		endfunction

		function void note_command(tdm_pkg::in_t c);
			logic [31:0] late, q, rt, p, df;
			int t;
			bit ok;
			tdm_pkg::out_t r;
			ok = 0;
			t = c.task_index;
			case (c.command)
				tdm_pkg::CMD_START: begin
					for (int i = 0; i < lim(); i++) rel[i] = c.now_time + per(i);
					armed = 1;
				end
				tdm_pkg::CMD_REPORT: begin
					df = c.now_time - rel[t];
					if (armed && t < lim() && !df[31]) begin
						p = per(t);
						late = c.start_time - rel[t];
						q = late / p;
						rt = c.complete_time - c.start_time;
						skp[t] = sadd(skp[t], q);
						rel[t] = rel[t] + (q + 1) * p;
						rtl_last[t] = rt;
						if (rt > rtpk[t]) rtpk[t] = rt;
						if (late > ltpk[t]) ltpk[t] = late;
						if ({32'd0, late} + {32'd0, rt} > {32'd0, p}) begin
							mis[t] = sadd(mis[t], 1);
							strk[t] = sadd(strk[t], 1);
							if (strk[t] == 2) ovr[t] = sadd(ovr[t], 1);
						end else begin
							strk[t] = 0;
						end
						nrun[t] = sadd(nrun[t], 1);
						done_at[t] = c.complete_time;
						ok = 1;
					end
				end
				tdm_pkg::CMD_CLEAR: for (int i = 0; i < lim(); i++) begin
					rtpk[i] = 0; ltpk[i] = 0;
				end
				tdm_pkg::CMD_GATE: ok = run_gate(c.now_time);
				tdm_pkg::CMD_GRESET: begin
					for (int i = 0; i < 4; i++) begin
						askp[i] = 0; aovr[i] = 0;
					end
					latch = 1;
				end
				default: ;
			endcase
			r.ok = ok; r.healthy = latch;
			r.skipped_count = skp[t]; r.miss_count = mis[t];
			r.consecutive_misses = strk[t]; r.overrun_count = ovr[t];
			r.run_total = nrun[t]; r.last_runtime = rtl_last[t];
			r.max_runtime = rtpk[t]; r.max_lateness = ltpk[t];
			r.last_complete = done_at[t]; r.next_release = rel[t];
			pending.push_back(r);
		endfunction

		function void fld(string nm, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s expected %0h actual %0h", nm, e, a);
				errors++;
			end
		endfunction

		function void check_result(tdm_pkg::out_t a);
			tdm_pkg::out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			e = pending.pop_front();
			fld("ok", e.ok, a.ok);
			fld("healthy", e.healthy, a.healthy);
			fld("skipped_count", e.skipped_count, a.skipped_count);
			fld("miss_count", e.miss_count, a.miss_count);
			fld("consecutive_misses", e.consecutive_misses, a.consecutive_misses);
			fld("overrun_count", e.overrun_count, a.overrun_count);
			fld("run_total", e.run_total, a.run_total);
			fld("last_runtime", e.last_runtime, a.last_runtime);
			fld("max_runtime", e.max_runtime, a.max_runtime);
			fld("max_lateness", e.max_lateness, a.max_lateness);
			fld("last_complete", e.last_complete, a.last_complete);
			fld("next_release", e.next_release, a.next_release);
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	tdm_pkg::in_t  in_data = '0;
	tdm_pkg::out_t out_data;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	bit   rx_random = 1;

	deadline_scoreboard sb;
	logic [31:0] clock_us;

	task_deadline_monitor u_top (.*);

	always #5 clk = ~clk;

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random stall, check at rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end
	always @(negedge clk) begin
		out_stall <= rx_random ? ($urandom_range(0, 99) < 25 ? 1'b1 :
			($urandom_range(0, 199) == 0 ? 1'b1 : 1'b0)) : 1'b0;
	end

	// valid drops low between transactions
	task send_cmd(tdm_pkg::in_t c);
		int g;
		g = gap_len();
		repeat (g + 1) @(negedge clk);
		in_data <= c;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_command(c);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task write_cfg(logic [2:0] idx, logic [31:0] val);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function tdm_pkg::in_t mk(logic [2:0] c, logic [1:0] t, logic [31:0] nw,
			logic [31:0] st, logic [31:0] ct);
		tdm_pkg::in_t x;
		x.command = c; x.task_index = t; x.now_time = nw;
		x.start_time = st; x.complete_time = ct;
		return x;
	endfunction

	// a run of a task near its release, with random jitter and runtime
	task report_near(logic [1:0] t);
		logic [31:0] p, st;
		p = sb.per(t);
		st = sb.rel[t] + ($urandom_range(0, 9) == 0 ? $urandom_range(0, 4 * p) :
			$urandom_range(0, 3));
		clock_us = st;
		send_cmd(mk(tdm_pkg::CMD_REPORT, t, st, st, st + $urandom_range(0, p + 3)));
	endtask

	task random_phase(int count);
		int k;
		logic [1:0] t;
		for (k = 0; k < count; k++) begin
			t = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: report_near(t);
				9: send_cmd(mk(tdm_pkg::CMD_START, t, clock_us, $urandom, $urandom));
				10: send_cmd(mk(tdm_pkg::CMD_CLEAR, t, $urandom, $urandom, $urandom));
				11, 12: send_cmd(mk(tdm_pkg::CMD_GATE, t, clock_us + $urandom_range(0, 8),
					$urandom, $urandom));
				13: send_cmd(mk(tdm_pkg::CMD_GRESET, t, $urandom, $urandom, $urandom));
				14, 15: send_cmd(mk(tdm_pkg::CMD_READ, t, $urandom, $urandom, $urandom));
				16: send_cmd(mk(3'($urandom_range(6, 7)), t, $urandom, $urandom, $urandom));
				default: send_cmd(mk(tdm_pkg::CMD_REPORT, t, $urandom, $urandom, $urandom));
			endcase
		end
	endtask

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int w;
		sb = new();
		sb.clear_all();
		clock_us = 32'h1000;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: before start, reads, unused codes, extremes
		send_cmd(mk(tdm_pkg::CMD_REPORT, 0, 0, 0, 0));
		send_cmd(mk(tdm_pkg::CMD_READ, 3, MAX32, MAX32, MAX32));
		send_cmd(mk(3'd6, 1, 0, 0, 0));
		send_cmd(mk(3'd7, 2, MAX32, 0, MAX32));
		write_cfg(tdm_pkg::REG_ACTIVE, 7);
		write_cfg(tdm_pkg::REG_PERIOD0, 0);
		write_cfg(tdm_pkg::REG_PERIOD1, 100);
		write_cfg(tdm_pkg::REG_PERIOD2, MAX32);
		write_cfg(tdm_pkg::REG_PERIOD3, 7);
		write_cfg(tdm_pkg::REG_CRITICAL, 4'hF);
		write_cfg(tdm_pkg::REG_TOLER, MAX32);
		send_cmd(mk(tdm_pkg::CMD_GATE, 0, 0, 0, 0));
		send_cmd(mk(tdm_pkg::CMD_START, 0, MAX32 - 50, 0, 0));
		send_cmd(mk(tdm_pkg::CMD_REPORT, 1, MAX32 - 60, 0, 0));
		send_cmd(mk(tdm_pkg::CMD_REPORT, 1, 60, 60, 30));
		send_cmd(mk(tdm_pkg::CMD_REPORT, 0, MAX32, MAX32, 0));
		send_cmd(mk(tdm_pkg::CMD_REPORT, 2, 32'h8000_0000, 32'h7FFF_FFFF, MAX32));
		send_cmd(mk(tdm_pkg::CMD_REPORT, 3, 500, 520, 600));
		send_cmd(mk(tdm_pkg::CMD_REPORT, 3, 530, 530, 700));
		send_cmd(mk(tdm_pkg::CMD_GATE, 3, 700, 0, 0));
		send_cmd(mk(tdm_pkg::CMD_GRESET, 0, 0, 0, 0));
		send_cmd(mk(tdm_pkg::CMD_CLEAR, 3, 0, 0, 0));
		send_cmd(mk(tdm_pkg::CMD_READ, 3, 0, 0, 0));
		write_cfg(tdm_pkg::REG_ACTIVE, 2);
		send_cmd(mk(tdm_pkg::CMD_REPORT, 3, MAX32, 0, 0));

		// random phases over several settings
		for (w = 0; w < 6; w++) begin
			rx_random = (w != 2);
			write_cfg(tdm_pkg::REG_ACTIVE, w == 5 ? 0 : $urandom_range(1, 5));
			write_cfg(tdm_pkg::REG_PERIOD0, w == 4 ? MAX32 : $urandom_range(0, 40));
			write_cfg(tdm_pkg::REG_PERIOD1, $urandom_range(1, 200));
			write_cfg(tdm_pkg::REG_PERIOD2, w == 3 ? 0 : $urandom_range(50, 5000));
			write_cfg(tdm_pkg::REG_PERIOD3, w == 1 ? 32'h8000_0000 : $urandom_range(1, 20));
			write_cfg(tdm_pkg::REG_CRITICAL, $urandom_range(0, 15));
			write_cfg(tdm_pkg::REG_TOLER, w == 0 ? 0 : $urandom_range(0, 50));
			clock_us = $urandom;
			send_cmd(mk(tdm_pkg::CMD_START, 0, clock_us, 0, 0));
			random_phase(250);
		end

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
